[design/i2crtc_pkg.sv]
// Shared constants, codes and helpers for the I2C clock-chip sequencer.
package i2crtc_pkg;

	localparam int unsigned XFER_BYTES = 3;
	localparam logic [1:0] XFER_CNT = 2'(XFER_BYTES);

	localparam logic [7:0] DEV_ADDR = 8'hD0;

	// Controller control bits
	localparam logic [6:0] F_STA = 7'h20;
	localparam logic [6:0] F_STO = 7'h10;
	localparam logic [6:0] F_SI  = 7'h08;
	localparam logic [6:0] F_AA  = 7'h04;

	typedef enum logic [1:0] {
		OP_START_WR = 2'd0,
		OP_START_RD = 2'd1,
		OP_STATUS   = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	// Bus controller status codes
	localparam logic [7:0] ST_BUS_ERR   = 8'h00;
	localparam logic [7:0] ST_START     = 8'h08;
	localparam logic [7:0] ST_RSTART    = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK  = 8'h18;
	localparam logic [7:0] ST_SLAW_NACK = 8'h20;
	localparam logic [7:0] ST_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST  = 8'h38;
	localparam logic [7:0] ST_SLAR_ACK  = 8'h40;
	localparam logic [7:0] ST_SLAR_NACK = 8'h48;
	localparam logic [7:0] ST_RX_ACK    = 8'h50;
	localparam logic [7:0] ST_RX_NACK   = 8'h58;

	// BCD byte with three-bit tens field
	function automatic logic [6:0] bcd_tens3(input logic [7:0] b);
		logic [6:0] tens;
		tens = {4'd0, b[6:4]};
		return {3'd0, b[3:0]} + (tens << 3) + (tens << 1);
	endfunction

	// BCD byte with two-bit tens field
	function automatic logic [5:0] bcd_tens2(input logic [7:0] b);
		logic [5:0] tens;
		tens = {4'd0, b[5:4]};
		return {2'd0, b[3:0]} + (tens << 3) + (tens << 1);
	endfunction

endpackage

[design/i2c_rtc_register_sequencer.sv]
// I2C master sequencer for a clock chip: start commands and bus status decode.
//
//  channel  | beat contents                                          | flow
//  ---------+--------------------------------------------------------+-----------------------
//  in       | opcode, bus_status, rx_byte, reg_address, wbyte0..2    | in_valid / in_stall
//  out      | ctrl_set, ctrl_clear, tx_valid, tx_byte, read_done,    | out_valid / out_stall
//           | value0..2                                              |
//
// One result beat per input beat. An input beat lands in the _s1 register, then
// the decode runs on it against the sequencer state and the result is caught in
// the output register; one beat per cycle while out_stall does not hold it.
// Sequencer state is updated as the beat moves from _s1 to the output register,
// so beats are handled strictly in order.
// in_stall rises only when _s1 is full and the output register is held by
// out_stall; the output register frees _s1 in the same cycle it is taken.
// arst_n clears valids and sequencer state but loads recv_left_q with XFER_CNT; byte buffers are not reset.
module i2c_rtc_register_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] opcode,
	input  logic [7:0] bus_status,
	input  logic [7:0] rx_byte,
	input  logic [7:0] reg_address,
	input  logic [7:0] wbyte0,
	input  logic [7:0] wbyte1,
	input  logic [7:0] wbyte2,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] ctrl_set,
	output logic [6:0] ctrl_clear,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       read_done,
	output logic [6:0] value0,
	output logic [6:0] value1,
	output logic [5:0] value2
);
	import i2crtc_pkg::*;

	// input stage
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] status_s1, rx_s1, reg_s1, wb0_s1, wb1_s1, wb2_s1;

	// sequencer state
	logic       read_bit_q, is_read_q, done_q;
	logic [7:0] target_q;
	logic [7:0] send_buf_q [3];
	logic [7:0] recv_buf_q [3];
	logic [1:0] send_idx_q, send_left_q, recv_idx_q, recv_left_q;

	// output register
	logic       out_valid_q;
	logic [6:0] set_q, clr_q, v0_q, v1_q;
	logic       txv_q, rd_q;
	logic [7:0] txb_q;
	logic [5:0] v2_q;

	logic advance, take_in;
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	// next-state and result decode
	logic       n_read_bit, n_is_read, n_done;
	logic [7:0] n_target;
	logic [1:0] n_send_idx, n_send_left, n_recv_idx, n_recv_left;
	logic       wr_send, wr_recv;
	logic [7:0] recv_new [3];
	logic [6:0] c_set, c_clr, c_v0, c_v1;
	logic       c_txv, c_rd;
	logic [7:0] c_txb;
	logic [5:0] c_v2;
	logic [1:0] send_sel;

	always_comb begin
		n_read_bit  = read_bit_q;
		n_is_read   = is_read_q;
		n_done      = done_q;
		n_target    = target_q;
		n_send_idx  = send_idx_q;
		n_send_left = send_left_q;
		n_recv_idx  = recv_idx_q;
		n_recv_left = recv_left_q;
		wr_send     = 1'b0;
		wr_recv     = 1'b0;
		c_set = '0;
		c_clr = '0;
		c_txv = 1'b0;
		c_txb = '0;
		c_rd  = 1'b0;
		c_v0  = '0;
		c_v1  = '0;
		c_v2  = '0;
		send_sel = (send_idx_q == 2'd3) ? 2'd2 : send_idx_q;
		for (int i = 0; i < 3; i++) begin
			recv_new[i] = recv_buf_q[i];
		end

		unique case (op_s1)
			OP_START_WR, OP_START_RD: begin
				n_read_bit  = 1'b0;
				n_done      = 1'b0;
				n_target    = reg_s1;
				n_send_idx  = '0;
				n_recv_idx  = '0;
				n_recv_left = XFER_CNT;
				if (op_s1 == OP_START_WR) begin
					wr_send     = 1'b1;
					n_send_left = XFER_CNT;
					n_is_read   = 1'b0;
				end else begin
					n_send_left = '0;
					n_is_read   = 1'b1;
				end
				c_set = F_STA;
				c_clr = F_STA | F_SI | F_AA;
			end
			OP_STATUS: begin
				c_clr = F_SI;
				unique case (status_s1)
					ST_BUS_ERR, ST_DATA_NACK, ST_SLAR_NACK: c_set = F_STO | F_AA;
					ST_START, ST_RSTART: begin
						c_txv = 1'b1;
						c_txb = DEV_ADDR | {7'd0, read_bit_q};
						c_clr = F_STA | F_SI;
					end
					ST_SLAW_ACK: begin
						c_txv = 1'b1;
						c_txb = target_q;
					end
					ST_SLAW_NACK: c_set = F_STO;
					ST_DATA_ACK: begin
						if (send_left_q == '0) begin
							if (is_read_q) begin
								n_read_bit = 1'b1;
								c_set      = F_STA;
							end else begin
								c_set = F_STO;
							end
						end else begin
							c_txv = 1'b1;
							c_txb = send_buf_q[send_sel];
							if (send_idx_q < 2'd2) n_send_idx = send_idx_q + 2'd1;
							n_send_left = send_left_q - 2'd1;
						end
					end
					ST_ARB_LOST: c_set = F_STA | F_AA;
					ST_SLAR_ACK: begin
						c_set = F_AA;
						if (recv_left_q != '0) n_recv_left = recv_left_q - 2'd1;
					end
					ST_RX_ACK: begin
						wr_recv = 1'b1;
						if (recv_idx_q != 2'd3) n_recv_idx = recv_idx_q + 2'd1;
						if (recv_left_q != '0) n_recv_left = recv_left_q - 2'd1;
						if (n_recv_left == '0) c_clr = F_SI | F_AA;
						else c_set = F_AA;
					end
					ST_RX_NACK: begin
						wr_recv = 1'b1;
						c_set   = F_STO | F_AA;
						n_done  = 1'b1;
						c_rd    = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		// received byte bypasses into the decode of the final beat
		if (wr_recv && recv_idx_q != 2'd3) recv_new[recv_idx_q] = rx_s1;
		if (c_rd) begin
			c_v0 = bcd_tens3(recv_new[0]);
			c_v1 = bcd_tens3(recv_new[1]);
			c_v2 = bcd_tens2(recv_new[2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			read_bit_q  <= 1'b0;
			is_read_q   <= 1'b0;
			done_q      <= 1'b0;
			target_q    <= '0;
			send_idx_q  <= '0;
			send_left_q <= '0;
			recv_idx_q  <= '0;
			recv_left_q <= XFER_CNT;
		end else begin
			if (take_in) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (advance) begin
				read_bit_q  <= n_read_bit;
				is_read_q   <= n_is_read;
				done_q      <= n_done;
				target_q    <= n_target;
				send_idx_q  <= n_send_idx;
				send_left_q <= n_send_left;
				recv_idx_q  <= n_recv_idx;
				recv_left_q <= n_recv_left;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (take_in) begin
			op_s1     <= op_t'(opcode);
			status_s1 <= bus_status;
			rx_s1     <= rx_byte;
			reg_s1    <= reg_address;
			wb0_s1    <= wbyte0;
			wb1_s1    <= wbyte1;
			wb2_s1    <= wbyte2;
		end
		if (advance) begin
			if (wr_send) begin
				send_buf_q[0] <= wb0_s1;
				send_buf_q[1] <= wb1_s1;
				send_buf_q[2] <= wb2_s1;
			end
			for (int i = 0; i < 3; i++) begin
				recv_buf_q[i] <= recv_new[i];
			end
			set_q <= c_set;
			clr_q <= c_clr;
			txv_q <= c_txv;
			txb_q <= c_txb;
			rd_q  <= c_rd;
			v0_q  <= c_v0;
			v1_q  <= c_v1;
			v2_q  <= c_v2;
		end
	end

	assign out_valid  = out_valid_q;
	assign ctrl_set   = set_q;
	assign ctrl_clear = clr_q;
	assign tx_valid   = txv_q;
	assign tx_byte    = txb_q;
	assign read_done  = rd_q;
	assign value0     = v0_q;
	assign value1     = v1_q;
	assign value2     = v2_q;

endmodule
